@@ hdl/iss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// shared types and constants of the insertion sorter
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int unsigned VALUE_W = 32;

	typedef enum logic [0:0] {
		ST_LOAD = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic ins;   // insert the accepted value
		logic pop;   // move the smallest entry into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;      // one entry left in the store
		logic out_free;  // output register can take a new result
		logic nonzero;   // store holds at least one entry
	} sts_t;

endpackage

@@ hdl/iss_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_stream_if
// valid/ready channels for input values and sorted results
// ----------------------------------------------------------------------------
interface iss_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [iss_pkg::VALUE_W-1:0]  value;
	logic                                end_of_set;

	modport source (output valid, output value, output end_of_set, input ready);
	modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

interface iss_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [iss_pkg::VALUE_W-1:0]  sorted_value;
	logic                                last_out;
	logic                                overflow;

	modport source (output valid, output sorted_value, output last_out, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input last_out, input overflow,
		output ready);
endinterface

@@ hdl/iss_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_ctrl
// load/emit sequencer of the insertion sorter
// ----------------------------------------------------------------------------
module iss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_eos,
	output logic          in_ready,
	input  iss_pkg::sts_t sts,
	output iss_pkg::cmd_t cmd
);

	iss_pkg::state_t state_q;
	iss_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iss_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			iss_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.ins  = in_valid;
				if (in_valid && in_eos) begin
					state_d = iss_pkg::ST_EMIT;
				end
			end
			iss_pkg::ST_EMIT: begin
				cmd.pop = sts.out_free;
				if (sts.out_free && sts.last) begin
					state_d = iss_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = iss_pkg::ST_LOAD;
			end
		endcase
	end

	// emission never starts or runs on an empty store
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iss_pkg::ST_EMIT |-> sts.nonzero)
		else $error("emit state with empty store");

	// no insert and pop in the same cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.pop))
		else $error("insert and pop together");

	// the final pop returns the controller to load
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && sts.last |=> state_q == iss_pkg::ST_LOAD)
		else $error("no return to load after last result");

endmodule

@@ hdl/iss_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_datapath
// sorted register chain with parallel compare/shift insert and shift-out
// ----------------------------------------------------------------------------
module iss_datapath #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  iss_pkg::cmd_t                      cmd,
	output iss_pkg::sts_t                      sts,
	input  logic signed [iss_pkg::VALUE_W-1:0] in_value,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [iss_pkg::VALUE_W-1:0] out_value,
	output logic                               out_last,
	output logic                               out_overflow
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic signed [iss_pkg::VALUE_W-1:0] val_q    [DEPTH];
	logic signed [iss_pkg::VALUE_W-1:0] val_d    [DEPTH];
	logic signed [iss_pkg::VALUE_W-1:0] val_prev [DEPTH];
	logic signed [iss_pkg::VALUE_W-1:0] val_next [DEPTH];
	logic [DEPTH-1:0]                   gt;
	logic [DEPTH-1:0]                   gt_prev;
	logic [CNT_W-1:0]                   count_q;
	logic                               dropped_q;
	logic                               full;
	logic                               ins_ok;
	logic                               out_valid_q;
	logic signed [iss_pkg::VALUE_W-1:0] out_value_q;
	logic                               out_last_q;
	logic                               out_ovf_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign ins_ok = cmd.ins && !full;

	// per cell: occupied and greater than the new value
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (val_q[i] > in_value);
		end
	end

	assign gt_prev = {gt[DEPTH-2:0], 1'b0};

	always_comb begin
		val_prev[0] = in_value;
		for (int i = 1; i < DEPTH; i++) begin
			val_prev[i] = val_q[i-1];
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			val_next[i] = val_q[i+1];
		end
		val_next[DEPTH-1] = val_q[DEPTH-1];
	end

	// cells at or above the insert point shift up, the new value lands at the boundary
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			val_d[i] = val_q[i];
			if (ins_ok) begin
				if (gt[i] || count_q == CNT_W'(i)) begin
					val_d[i] = gt_prev[i] ? val_prev[i] : in_value;
				end
			end else if (cmd.pop) begin
				val_d[i] = val_next[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			val_q[i] <= val_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.ins && full) begin
				dropped_q <= 1'b1;
			end
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_value_q <= val_q[0];
			out_last_q  <= (count_q == CNT_W'(1));
			out_ovf_q   <= dropped_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_last     = out_last_q;
	assign out_overflow = out_ovf_q;

	assign sts.last     = (count_q == CNT_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.nonzero  = (count_q != '0);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count beyond depth");

	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins && full |=> dropped_q)
		else $error("dropped value not flagged");

	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && count_q == CNT_W'(1) |=> count_q == '0 && !dropped_q)
		else $error("set state not cleared after last result");

endmodule

@@ hdl/insertion_sorter_unit.sv @@
`timescale 1ns / 1ps
// loading: a value is placed in the sorted chain at the edge that accepts it; the first
//   result is registered once the controller is in emit and the output register is free
// throughput: one value per cycle while loading; a set is then emitted through the output
//   register, and no input is taken during emission
// reset: arst_n clears count, overflow flag, controller state and output valid at once
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// stable insertion sorter: collects signed values of a set in ascending order and
// emits the stored entries on end_of_set, with last and overflow marks
// ----------------------------------------------------------------------------
module insertion_sorter_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	iss_in_if.sink     item,
	iss_out_if.source  result
);

	// command and status between sequencer and datapath
	iss_pkg::cmd_t cmd;
	iss_pkg::sts_t sts;

	// sequencer: load values until end_of_set, then drain the chain one per free slot
	iss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_eos   (item.end_of_set),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: register chain compares every cell against the incoming value in
	// parallel and shifts the larger ones up; emission shifts the chain down so
	// the smallest entry always sits in cell zero
	iss_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_value     (item.value),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_value    (result.sorted_value),
		.out_last     (result.last_out),
		.out_overflow (result.overflow)
	);

endmodule
